// File: rtl/multipart_boundary_parser_core_assert.svh
// Assertion helpers for the RTL of the multipart boundary parser; mbp_control includes them.
// Each macro expands to one labeled concurrent assertion that is clocked by
// i_clk and disabled while i_rst_n is low.
`ifndef MULTIPART_BOUNDARY_PARSER_CORE_ASSERT_SVH
`define MULTIPART_BOUNDARY_PARSER_CORE_ASSERT_SVH

// Same-cycle implication.
`define MBP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define MBP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/mbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbp_pkg
// Types, codes and constants shared by the multipart boundary parser.
// ----------------------------------------------------------------------------
package mbp_pkg;

    localparam int MAX_BOUNDARY = 44;
    localparam int HOLD_DEPTH   = 52;
    localparam int IDX_W        = 6;

    localparam logic [1:0] OP_STREAM  = 2'd0;
    localparam logic [1:0] OP_LOAD    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
    localparam logic [2:0] KIND_BEGIN     = 3'd1;
    localparam logic [2:0] KIND_HDR_END   = 3'd2;
    localparam logic [2:0] KIND_PART_END  = 3'd3;
    localparam logic [2:0] KIND_ERROR     = 3'd4;
    localparam logic [2:0] KIND_NAME      = 3'd5;
    localparam logic [2:0] KIND_VALUE     = 3'd6;
    localparam logic [2:0] KIND_VALUE_END = 3'd7;

    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_HYPHEN = 8'd45;
    localparam logic [7:0] CH_COLON  = 8'd58;
    localparam logic [7:0] CH_SPACE  = 8'd32;

    typedef enum logic [3:0] {
        PH_ERROR       = 4'd0,
        PH_OPEN        = 4'd1,
        PH_FIELD       = 4'd2,
        PH_FINAL_LF    = 4'd3,
        PH_VALUE_START = 4'd4,
        PH_VALUE       = 4'd5,
        PH_VALUE_LF    = 4'd6,
        PH_PAYLOAD     = 4'd7,
        PH_DONE        = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_EMIT0,
        S_EMIT1,
        S_PRIME,
        S_RELEASE,
        S_TAIL
    } t_ctl_state;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] byte_value;
        logic [5:0] load_index;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  out_byte;
        logic [31:0] content_offset;
        logic        final_part;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic eval;
        logic load0;
        logic load1;
        logic rel_step;
        logic tail_pay;
        logic tail_hold;
    } t_dp_cmd;

    typedef struct packed {
        logic slot_free;
        logic eval_has0;
        logic eval_rel;
        logic has1;
        logic rel_done;
        logic tail_pay;
    } t_dp_status;

    // Token characters allowed in a header name.
    function automatic logic token_ok(input logic [7:0] c);
        return c inside {8'd33, [8'd35:8'd39], 8'd42, 8'd43, 8'd45, 8'd46,
                         [8'd48:8'd57], [8'd65:8'd90], [8'd94:8'd122],
                         8'd124, 8'd126};
    endfunction

endpackage

// File: rtl/mbp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/mbp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbp_datapath
// Parser state, boundary and hold memories, result evaluation and the
// output register of the multipart boundary parser.
// ----------------------------------------------------------------------------
module mbp_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mbp_pkg::t_in_item     i_in_data,
    input  logic [5:0]            i_blen,
    input  mbp_pkg::t_dp_cmd      i_cmd,
    output mbp_pkg::t_dp_status   o_status,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output mbp_pkg::t_out_item    o_out_data
);
    import mbp_pkg::*;

    t_in_item    r_item;
    t_phase      r_phase, n_phase;
    logic [5:0]  r_match, n_match;
    logic        r_closing, n_closing;
    logic [7:0]  r_name, n_name;
    logic [31:0] r_part_offset, n_part_offset;

    t_out_item   r_res0, n_res0;
    logic        n_has0;
    logic        r_has1, n_has1;
    logic        n_rel;
    logic [5:0]  r_rel_idx, n_rel_idx;
    logic [5:0]  r_rel_end;

    logic        r_out_valid;
    t_out_item   r_out;
    t_out_item   w_out0;
    t_out_item   w_out1;

    logic [7:0]  w_bnd_rdata;
    logic [7:0]  w_hold_rdata;
    logic        w_hold_we;
    logic [5:0]  w_hold_waddr;
    logic [7:0]  w_hold_wdata;
    logic        w_bnd_we;

    logic [6:0]  w_len;
    logic [6:0]  w_m;
    logic [7:0]  w_c;
    logic [7:0]  w_dch;
    logic        w_slot_free;

    assign w_len = {1'b0, i_blen} + 7'd4;
    assign w_m   = {1'b0, r_match};
    assign w_c   = r_item.byte_value;
    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        case (r_match)
            6'd0:       w_dch = CH_CR;
            6'd1:       w_dch = CH_LF;
            6'd2, 6'd3: w_dch = CH_HYPHEN;
            default:    w_dch = w_bnd_rdata;
        endcase
    end

    // Evaluation of one request against the parser state.
    always_comb begin
        n_phase       = r_phase;
        n_match       = r_match;
        n_closing     = r_closing;
        n_name        = r_name;
        n_part_offset = r_part_offset;
        n_res0        = '0;
        n_has0        = 1'b0;
        n_has1        = 1'b0;
        n_rel         = 1'b0;
        case (r_item.op)
            OP_STREAM: begin
                case (r_phase)
                    PH_OPEN: begin
                        if (w_m < w_len) begin
                            if (w_c != w_dch) begin
                                n_phase = PH_ERROR;
                                n_has0 = 1'b1;
                                n_res0.kind = KIND_ERROR;
                            end else begin
                                n_match = r_match + 6'd1;
                            end
                        end else if (w_m == w_len) begin
                            if (w_c != CH_CR) begin
                                n_phase = PH_ERROR;
                                n_has0 = 1'b1;
                                n_res0.kind = KIND_ERROR;
                            end else begin
                                n_match = r_match + 6'd1;
                            end
                        end else if (w_m == w_len + 7'd1 && w_c == CH_LF) begin
                            n_match = '0;
                            n_name = '0;
                            n_phase = PH_FIELD;
                            n_has0 = 1'b1;
                            n_res0.kind = KIND_BEGIN;
                        end else begin
                            n_phase = PH_ERROR;
                            n_has0 = 1'b1;
                            n_res0.kind = KIND_ERROR;
                        end
                    end
                    PH_FIELD: begin
                        if (w_c == CH_CR) begin
                            n_phase = PH_FINAL_LF;
                        end else if (w_c == CH_COLON) begin
                            if (r_name == '0) begin
                                n_phase = PH_ERROR;
                                n_has0 = 1'b1;
                                n_res0.kind = KIND_ERROR;
                            end else begin
                                n_phase = PH_VALUE_START;
                            end
                        end else if (token_ok(w_c)) begin
                            if (r_name != 8'hFF) begin
                                n_name = r_name + 8'd1;
                            end
                            n_has0 = 1'b1;
                            n_res0.kind = KIND_NAME;
                            n_res0.out_byte = w_c;
                        end else begin
                            n_phase = PH_ERROR;
                            n_has0 = 1'b1;
                            n_res0.kind = KIND_ERROR;
                        end
                    end
                    PH_FINAL_LF: begin
                        if (w_c != CH_LF) begin
                            n_phase = PH_ERROR;
                            n_has0 = 1'b1;
                            n_res0.kind = KIND_ERROR;
                        end else begin
                            n_phase = PH_PAYLOAD;
                            n_part_offset = '0;
                            n_match = '0;
                            n_closing = 1'b0;
                            n_has0 = 1'b1;
                            n_res0.kind = KIND_HDR_END;
                        end
                    end
                    PH_VALUE_START, PH_VALUE: begin
                        if (r_phase == PH_VALUE_START && w_c == CH_SPACE) begin
                            n_phase = r_phase;
                        end else if (w_c == CH_CR) begin
                            n_phase = PH_VALUE_LF;
                            n_has0 = 1'b1;
                            n_res0.kind = KIND_VALUE_END;
                        end else begin
                            n_phase = PH_VALUE;
                            n_has0 = 1'b1;
                            n_res0.kind = KIND_VALUE;
                            n_res0.out_byte = w_c;
                        end
                    end
                    PH_VALUE_LF: begin
                        if (w_c != CH_LF) begin
                            n_phase = PH_ERROR;
                            n_has0 = 1'b1;
                            n_res0.kind = KIND_ERROR;
                        end else begin
                            n_phase = PH_FIELD;
                            n_name = '0;
                        end
                    end
                    PH_PAYLOAD: begin
                        if (r_match == '0) begin
                            if (w_c == CH_CR) begin
                                n_match = 6'd1;
                            end else begin
                                n_has0 = 1'b1;
                                n_res0.kind = KIND_PAYLOAD;
                                n_res0.out_byte = w_c;
                                n_res0.content_offset = r_part_offset;
                                n_part_offset = r_part_offset + 32'd1;
                            end
                        end else if (w_m < w_len && w_c == w_dch) begin
                            n_match = r_match + 6'd1;
                        end else if (w_m == w_len && w_c == CH_HYPHEN) begin
                            n_closing = 1'b1;
                            n_match = r_match + 6'd1;
                        end else if (w_m == w_len && w_c == CH_CR) begin
                            n_closing = 1'b0;
                            n_match = r_match + 6'd1;
                        end else if ((w_m == w_len + 7'd1 && r_closing && w_c == CH_HYPHEN)
                                || (w_m == w_len + 7'd2 && r_closing && w_c == CH_CR)) begin
                            n_match = r_match + 6'd1;
                        end else if ((w_m == w_len + 7'd1 && !r_closing && w_c == CH_LF)
                                || (w_m == w_len + 7'd3 && r_closing && w_c == CH_LF)) begin
                            // Complete delimiter: the part ends here.
                            n_has0 = 1'b1;
                            n_res0.kind = KIND_PART_END;
                            n_res0.final_part = r_closing;
                            n_match = '0;
                            n_part_offset = '0;
                            if (r_closing) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_phase = PH_FIELD;
                                n_name = '0;
                                n_has1 = 1'b1;
                            end
                        end else begin
                            // Mismatch: held bytes go out, then the byte is retried.
                            n_rel = 1'b1;
                            n_closing = 1'b0;
                            n_match = (w_c == CH_CR) ? 6'd1 : 6'd0;
                        end
                    end
                    PH_DONE: begin
                        n_phase = r_phase;
                    end
                    default: begin
                        n_phase = PH_ERROR;
                        n_has0 = 1'b1;
                        n_res0.kind = KIND_ERROR;
                    end
                endcase
            end
            OP_RESTART: begin
                n_phase = PH_OPEN;
                n_match = 6'd2;
                n_closing = 1'b0;
                n_name = '0;
                n_part_offset = '0;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // First and second result words as they enter the output register.
    always_comb begin
        w_out0      = r_res0;
        w_out0.last = !r_has1;
        w_out1      = '0;
        w_out1.kind = KIND_BEGIN;
        w_out1.last = 1'b1;
    end

    assign n_rel_idx = i_cmd.eval ? 6'd0 :
                       (i_cmd.rel_step ? r_rel_idx + 6'd1 : r_rel_idx);

    assign w_bnd_we = i_cmd.eval && r_item.op == OP_LOAD
                      && r_item.load_index < 6'(MAX_BOUNDARY);

    assign w_hold_we    = (i_cmd.eval && r_item.op == OP_STREAM && r_phase == PH_PAYLOAD)
                          || i_cmd.tail_hold;
    assign w_hold_waddr = i_cmd.tail_hold ? 6'd0 : r_match;
    assign w_hold_wdata = i_cmd.tail_hold ? CH_CR : w_c;

    mbp_ram #(.WIDTH(8), .DEPTH(MAX_BOUNDARY)) u_bnd_ram (
        .i_clk   (i_clk),
        .i_we    (w_bnd_we),
        .i_waddr (r_item.load_index),
        .i_wdata (r_item.byte_value),
        .i_raddr (r_match - 6'd4),
        .o_rdata (w_bnd_rdata)
    );

    mbp_ram #(.WIDTH(8), .DEPTH(HOLD_DEPTH)) u_hold_ram (
        .i_clk   (i_clk),
        .i_we    (w_hold_we),
        .i_waddr (w_hold_waddr),
        .i_wdata (w_hold_wdata),
        .i_raddr (n_rel_idx),
        .o_rdata (w_hold_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_ERROR;
            r_match       <= '0;
            r_closing     <= 1'b0;
            r_name        <= '0;
            r_part_offset <= '0;
            r_out_valid   <= 1'b0;
            r_has1        <= 1'b0;
            r_rel_idx     <= '0;
        end else begin
            r_rel_idx <= n_rel_idx;
            if (i_cmd.eval) begin
                r_phase       <= n_phase;
                r_match       <= n_match;
                r_closing     <= n_closing;
                r_name        <= n_name;
                r_part_offset <= n_part_offset;
                r_has1        <= n_has1;
            end else if (i_cmd.rel_step || i_cmd.tail_pay) begin
                r_part_offset <= r_part_offset + 32'd1;
            end
            if (i_cmd.load0 || i_cmd.load1 || i_cmd.rel_step || i_cmd.tail_pay) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in_data;
        end
        if (i_cmd.eval) begin
            r_res0    <= n_res0;
            r_rel_end <= r_match - 6'd1;
        end
        if (i_cmd.load0) begin
            r_out <= w_out0;
        end else if (i_cmd.load1) begin
            r_out <= w_out1;
        end else if (i_cmd.rel_step) begin
            r_out.kind           <= KIND_PAYLOAD;
            r_out.out_byte       <= w_hold_rdata;
            r_out.content_offset <= r_part_offset;
            r_out.final_part     <= 1'b0;
            r_out.last           <= (r_rel_idx == r_rel_end) && (w_c == CH_CR);
        end else if (i_cmd.tail_pay) begin
            r_out.kind           <= KIND_PAYLOAD;
            r_out.out_byte       <= w_c;
            r_out.content_offset <= r_part_offset;
            r_out.final_part     <= 1'b0;
            r_out.last           <= 1'b1;
        end
    end

    assign o_status.slot_free = w_slot_free;
    assign o_status.eval_has0 = n_has0;
    assign o_status.eval_rel  = n_rel;
    assign o_status.has1      = r_has1;
    assign o_status.rel_done  = r_rel_idx == r_rel_end;
    assign o_status.tail_pay  = w_c != CH_CR;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/mbp_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbp_control
// Sequencer that steps one request through evaluation and result delivery.
// ----------------------------------------------------------------------------
`include "multipart_boundary_parser_core_assert.svh"

module mbp_control (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mbp_pkg::t_dp_status  i_status,
    output mbp_pkg::t_dp_cmd     o_cmd
);
    import mbp_pkg::*;

    t_ctl_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_status.eval_rel) begin
                    n_state = S_PRIME;
                end else if (i_status.eval_has0) begin
                    n_state = S_EMIT0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT0: begin
                if (i_status.slot_free) begin
                    n_state = i_status.has1 ? S_EMIT1 : S_IDLE;
                end
            end
            S_EMIT1: begin
                if (i_status.slot_free) begin
                    n_state = S_IDLE;
                end
            end
            S_PRIME: begin
                n_state = S_RELEASE;
            end
            S_RELEASE: begin
                if (i_status.slot_free && i_status.rel_done) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                if (!i_status.tail_pay || i_status.slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:    o_cmd.accept    = i_in_valid;
            S_EVAL:    o_cmd.eval      = 1'b1;
            S_EMIT0:   o_cmd.load0     = i_status.slot_free;
            S_EMIT1:   o_cmd.load1     = i_status.slot_free;
            S_RELEASE: o_cmd.rel_step  = i_status.slot_free;
            S_TAIL: begin
                o_cmd.tail_pay  = i_status.tail_pay && i_status.slot_free;
                o_cmd.tail_hold = !i_status.tail_pay;
            end
            default:   o_cmd = '0;
        endcase
    end

    assign o_in_stall = r_state != S_IDLE;

    `MBP_ASSERT_NEXT(a_accept_evals, o_cmd.accept, r_state == S_EVAL)
    `MBP_ASSERT_NEXT(a_release_holds,
                     r_state == S_RELEASE && !i_status.slot_free,
                     r_state == S_RELEASE)
    `MBP_ASSERT_NOW(a_begin_after_end, r_state == S_EMIT1,
                    $past(r_state) == S_EMIT0 || $past(r_state) == S_EMIT1)
    `MBP_ASSERT_NEXT(a_prime_once, r_state == S_PRIME, r_state == S_RELEASE)

endmodule

// File: rtl/multipart_boundary_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multipart_boundary_parser_core
// Byte-serial multipart/form-data body parser with a loadable boundary.
// ----------------------------------------------------------------------------
// Usage: requests enter on i_in_valid / o_in_stall / i_in_data. A request either
// streams a body byte, loads one boundary text byte, or restarts the parse at
// the opening delimiter. Results leave on o_out_valid / i_out_stall /
// o_out_data; the last result of a request carries the last flag, and a
// request may cause no result at all.
// The boundary length is set through the APB port at byte addresses 0 to 3. The
// user must set the boundary length only while the block is idle; the block
// itself does not enforce this. Values out of range are clamped into 1 to 44.
// A request is accepted only in the idle state and is evaluated in the next
// cycle; its results then enter the output register whenever it is free. A
// delimiter mismatch in payload adds steps that prime the hold memory read
// (its single read port is registered), release the held bytes, and then
// re-arm on a carriage return or emit the byte as payload.
// After reset the parser sits in the error state and answers each streamed
// byte with an error result until a restart request arrives; the boundary
// text is undefined until loaded. While the receiver stalls, the output
// register keeps its result and the sequencer waits; no result is dropped.
// ----------------------------------------------------------------------------
module multipart_boundary_parser_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  mbp_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output mbp_pkg::t_out_item          o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import mbp_pkg::*;

    logic [5:0]  r_blen;
    logic [5:0]  w_wr_len;
    logic        w_cfg_write;
    t_dp_cmd     w_cmd;
    t_dp_status  w_status;

    // The register stores a clamped length so that the delimiter compare
    // never runs past the end of the boundary memory.
    assign w_cfg_write = psel && penable && pwrite && pready && !paddr[2];

    always_comb begin
        if (pwdata[5:0] == 6'd0) begin
            w_wr_len = 6'd1;
        end else if (pwdata[5:0] > 6'(MAX_BOUNDARY)) begin
            w_wr_len = 6'(MAX_BOUNDARY);
        end else begin
            w_wr_len = pwdata[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blen <= 6'd1;
        end else if (w_cfg_write) begin
            r_blen <= w_wr_len;
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {26'd0, r_blen};

    // The sequencer owns the request handshake; the datapath owns the parser state.
    mbp_control u_control (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    mbp_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_blen      (r_blen),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
